/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif

`endif

/* src/stip_pkg.sv */
// ----------------------------------------------------------------------------
// stip_pkg
// Types, character codes and helpers for the string-to-integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

	localparam int CH_W    = 8;
	localparam int BASE_W  = 6;
	localparam int VALUE_W = 64;
	localparam int OFF_W   = 12;
	localparam int PROD_W  = VALUE_W + BASE_W;

	localparam int MAX_STRING_LEN_DEF = 4096;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd63;

	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_LA    = 8'h61;
	localparam logic [CH_W-1:0] CH_LZ    = 8'h7a;
	localparam logic [CH_W-1:0] CH_UA    = 8'h41;
	localparam logic [CH_W-1:0] CH_UZ    = 8'h5a;
	localparam logic [CH_W-1:0] CH_LX    = 8'h78;
	localparam logic [CH_W-1:0] CH_UX    = 8'h58;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;

	localparam logic [VALUE_W-1:0] TOP_MAG = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGN,
		PH_ZERO,
		PH_ZEROX,
		PH_DIGITS
	} phase_t;

	// digit value in base 36, NO_DIGIT for anything else
	function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
		logic [BASE_W-1:0] d;
		d = NO_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = BASE_W'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = BASE_W'(c - CH_LA) + BASE_DEC;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = BASE_W'(c - CH_UA) + BASE_DEC;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [CH_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

/* src/string_to_integer_parser.sv */
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming strtol-style parser: one character per word, one result per string.
// ----------------------------------------------------------------------------
// Takes one character per cycle; a word with s_tuser set starts a new string
// and samples number_base (2..36, 0 = pick from prefix). Each character is
// handled in one pass of logic between the input register and the result
// register, the critical path being a 64x6 multiply-add of the digit
// accumulator, so the block sustains one character per clock and a result
// is registered when the character that ends the number (or the first
// character, for an invalid base) leaves the input register. The input side
// stalls only while a result waits on m_tready. Overflow wraps the value
// modulo 2^64 and sets the overflow bit; end_offset saturates near MAX_STRING_LEN.
`include "assert_macros.svh"

module string_to_integer_parser
	import stip_pkg::*;
#(
	parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              number_base_we,
	input  logic [BASE_W-1:0] number_base_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] ch
	input  logic              s_tuser,   // [0] start_req
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [79:0]       m_tdata    // [63:0] value, [64] formed,
	                                     // [76:65] end_offset, [77] overflow
);

	localparam int OFF_CAP_I = ((MAX_STRING_LEN - 1) < 4095) ? (MAX_STRING_LEN - 1) : 4095;
	localparam logic [OFF_W-1:0] OFF_CAP = OFF_W'(OFF_CAP_I);
	localparam logic [PROD_W-1:0] TOP_P = PROD_W'(TOP_MAG);

	logic [BASE_W-1:0]  nb_q;
	phase_t             phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [VALUE_W-1:0] mag_q, mag_d;     // magnitude accumulated so far, sign held in neg_q
	logic [BASE_W-1:0]  ab_q, ab_d;
	logic [OFF_W-1:0]   cc_q, cc_d;
	logic [OFF_W-1:0]   pe_q, pe_d;
	logic               ovf_q, ovf_d;

	logic              s1_valid;
	logic [CH_W-1:0]   ch_s1;
	logic              start_s1;
	logic              s1_fire;

	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               formed_q;
	logic [OFF_W-1:0]   end_q;
	logic               ovr_q;

	// character decode
	logic [BASE_W-1:0] dig;
	logic              is_ws, is_minus, is_plus, is_zero, is_x, is_alnum;
	logic              x_ok;
	logic [BASE_W-1:0] acc_base;
	logic              dig_ok;
	logic [PROD_W-1:0] prod;
	logic              acc_ovf;
	logic [OFF_W-1:0]  cc_next, pe_plus1;

	// leading part of a number (first non-space, non-sign character)
	logic [BASE_W-1:0] bs_base, bs_beff;
	logic              bs_zero, bs_fail;
	phase_t            bs_phase;
	logic              start_bad, start_body;

	logic              emit, emit_formed;
	logic [OFF_W-1:0]  emit_end;

	assign s1_fire  = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || s1_fire;

	assign dig      = digit_of(ch_s1);
	assign is_ws    = is_space(ch_s1);
	assign is_minus = (ch_s1 == CH_MINUS);
	assign is_plus  = (ch_s1 == CH_PLUS);
	assign is_zero  = (ch_s1 == CH_ZERO);
	assign is_x     = (ch_s1 == CH_LX) || (ch_s1 == CH_UX);
	assign is_alnum = (dig != NO_DIGIT);
	assign x_ok     = is_x && (ab_q == BASE_AUTO || ab_q == BASE_HEX);

	// a lone leading zero in auto mode means octal
	assign acc_base = (phase_q == PH_ZERO && ab_q == BASE_AUTO) ? BASE_OCT : ab_q;
	assign dig_ok   = (dig < acc_base);
	assign prod     = PROD_W'(mag_q) * PROD_W'(acc_base) + PROD_W'(dig);
	assign acc_ovf  = !ovf_q && (acc_base >= BASE_MIN) && (prod > TOP_P);

	assign cc_next  = (cc_q >= OFF_CAP) ? OFF_CAP : cc_q + OFF_W'(1);
	assign pe_plus1 = (pe_q >= OFF_CAP) ? OFF_CAP : pe_q + OFF_W'(1);

	assign bs_base    = start_s1 ? nb_q : ab_q;
	assign bs_zero    = is_zero && (bs_base == BASE_AUTO || bs_base == BASE_HEX);
	assign bs_beff    = (bs_base == BASE_AUTO) ? BASE_DEC : bs_base;
	assign bs_fail    = !bs_zero && (dig >= bs_beff);
	assign bs_phase   = bs_zero ? PH_ZERO : (bs_fail ? PH_IDLE : PH_DIGITS);
	assign start_bad  = (nb_q == BASE_ONE) || (nb_q > BASE_MAX);
	assign start_body = is_alnum || !(is_ws || is_minus || is_plus);

	// next state
	always_comb begin
		phase_d = phase_q;
		if (s1_fire) begin
			if (start_s1) begin
				if (start_bad) begin
					phase_d = PH_IDLE;
				end else if (start_body) begin
					phase_d = bs_phase;
				end else if (is_ws) begin
					phase_d = PH_LEAD;
				end else begin
					phase_d = PH_SIGN;
				end
			end else begin
				case (phase_q)
					PH_IDLE: begin
						phase_d = PH_IDLE;
					end
					PH_LEAD: begin
						if (is_ws) begin
							phase_d = PH_LEAD;
						end else if (is_minus || is_plus) begin
							phase_d = PH_SIGN;
						end else begin
							phase_d = bs_phase;
						end
					end
					PH_SIGN: begin
						phase_d = bs_phase;
					end
					PH_ZERO: begin
						if (x_ok) begin
							phase_d = PH_ZEROX;
						end else begin
							phase_d = dig_ok ? PH_DIGITS : PH_IDLE;
						end
					end
					PH_ZEROX: begin
						phase_d = (dig < BASE_HEX) ? PH_DIGITS : PH_IDLE;
					end
					PH_DIGITS: begin
						phase_d = dig_ok ? PH_DIGITS : PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// datapath and result
	always_comb begin
		neg_d       = neg_q;
		mag_d       = mag_q;
		ab_d        = ab_q;
		cc_d        = cc_q;
		pe_d        = pe_q;
		ovf_d       = ovf_q;
		emit        = 1'b0;
		emit_formed = 1'b0;
		emit_end    = '0;
		if (s1_fire) begin
			if (start_s1) begin
				neg_d = 1'b0;
				mag_d = '0;
				ovf_d = 1'b0;
				pe_d  = '0;
				ab_d  = nb_q;
				cc_d  = (OFF_CAP >= OFF_W'(1)) ? OFF_W'(1) : OFF_CAP;
				if (start_bad) begin
					emit = 1'b1;
				end else if (start_body) begin
					mag_d = bs_zero ? '0 : VALUE_W'(dig);
					if (bs_base == BASE_AUTO && !bs_zero) begin
						ab_d = BASE_DEC;
					end
					emit = bs_fail;
				end else if (is_minus) begin
					neg_d = 1'b1;
				end
			end else if (phase_q != PH_IDLE) begin
				cc_d = cc_next;
				case (phase_q)
					PH_LEAD, PH_SIGN: begin
						if (phase_q == PH_LEAD && (is_ws || is_plus)) begin
							neg_d = neg_q;
						end else if (phase_q == PH_LEAD && is_minus) begin
							neg_d = 1'b1;
						end else begin
							mag_d = bs_zero ? '0 : VALUE_W'(dig);
							if (bs_zero) begin
								pe_d = cc_q;
							end
							if (bs_base == BASE_AUTO && !bs_zero) begin
								ab_d = BASE_DEC;
							end
							emit = bs_fail;
						end
					end
					PH_ZERO, PH_DIGITS: begin
						if (phase_q == PH_ZERO && x_ok) begin
							ab_d = BASE_HEX;
						end else begin
							ab_d = acc_base;
							if (dig_ok) begin
								mag_d = prod[VALUE_W-1:0];
								if (acc_ovf) begin
									ovf_d = 1'b1;
								end
							end else begin
								emit        = 1'b1;
								emit_formed = 1'b1;
								emit_end    = cc_q;
							end
						end
					end
					PH_ZEROX: begin
						if (dig < BASE_HEX) begin
							mag_d = VALUE_W'(dig);
						end else begin
							// "0x" with no hex digit: the number is the zero
							emit        = 1'b1;
							emit_formed = 1'b1;
							emit_end    = pe_plus1;
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q    <= BASE_RESET;
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			ab_q    <= '0;
			cc_q    <= '0;
			pe_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (number_base_we) begin
				nb_q <= number_base_wdata;
			end
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			ab_q    <= ab_d;
			cc_q    <= cc_d;
			pe_q    <= pe_d;
			ovf_q   <= ovf_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			formed_q <= emit_formed;
			end_q    <= emit_formed ? emit_end : '0;
			if (emit_formed) begin
				value_q <= neg_q ? (VALUE_W'(0) - mag_q) : mag_q;
				ovr_q   <= ovf_q || (!neg_q && mag_q == TOP_MAG);
			end else begin
				value_q <= '0;
				ovr_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, ovr_q, end_q, formed_q, value_q};

	`ASSERT_NEVER(a_nf_clean, clk, arst_n, m_tvalid && !m_tdata[64] && (m_tdata[77:65] != '0 || m_tdata[63:0] != '0), "result without number carries nonzero fields")
	`ASSERT_NEVER(a_off_cap, clk, arst_n, m_tvalid && (m_tdata[76:65] > OFF_CAP), "end_offset above cap")
	`ASSERT_AT(a_digit_base, clk, arst_n, (phase_q == PH_DIGITS) |-> (ab_q >= BASE_MIN && ab_q <= BASE_MAX), "digit phase with invalid base")
	`ASSERT_AT(a_zerox_hex, clk, arst_n, (phase_q == PH_ZEROX) |-> (ab_q == BASE_HEX), "hex prefix phase without base 16")

endmodule
